@@ rtl/kot_pkg.sv @@
// shared types, constants and helpers for the keyed override table
package kot_pkg;

    localparam int KEY_W   = 8;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int MAX_BYTES = 8;
    localparam int ACT_W   = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [ACT_W-1:0] ACT_FIND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_entry;

    // broadcast to every cell during the execute cycle
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic              set_en;
        logic              append;
        logic              clear_en;
    } t_cmd;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            if (LEN_W'(b) < len) begin
                m[8*b +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic len_valid(input logic [LEN_W-1:0] len);
        return (len != '0) && (len <= LEN_W'(MAX_BYTES));
    endfunction

endpackage

@@ rtl/keyed_override_table.sv @@
// keyed override table: a row of cells searched in parallel, kept dense in insertion order
// an accepted beat moves the block to the execute state, and the result registers
//   are loaded as the block leaves that state
// a new beat is accepted only in idle; busy is high for the single execute cycle,
//   in which all cells compare, write or shift at once
// the receiver cannot stall; results are shown for one cycle on o_valid
// reset (synchronous, active low) empties the table at once; no clearing pass
module keyed_override_table #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kot_pkg::ACT_W-1:0]     i_action,
    input  logic [kot_pkg::KEY_W-1:0]     i_reg_addr,
    input  logic [kot_pkg::DATA_W-1:0]    i_payload,
    input  logic [kot_pkg::LEN_W-1:0]     i_payload_len,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic [kot_pkg::LEN_W-1:0]     o_found_len,
    output logic [kot_pkg::DATA_W-1:0]    o_found_data,
    output logic [kot_pkg::COUNT_OUT_W-1:0] o_entry_count
);
    import kot_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state             r_state;
    logic [ACT_W-1:0]   r_action;
    logic [KEY_W-1:0]   r_key;
    logic [LEN_W-1:0]   r_len;
    logic [DATA_W-1:0]  r_data;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic               r_ok;
    logic               n_ok;
    logic [LEN_W-1:0]   r_flen;
    logic [LEN_W-1:0]   n_flen;
    logic [DATA_W-1:0]  r_fdata;
    logic [DATA_W-1:0]  n_fdata;
    logic [COUNT_OUT_W-1:0] r_ecount;
    logic [XW-1:0]      count_x;

    t_cmd               cmd;
    t_entry             ent   [ENTRIES];
    logic [ENTRIES-1:0] hit;
    logic [ENTRIES-1:0] chain;
    logic               any_hit;
    logic               full;
    logic               len_ok;
    logic               exec;

    assign exec    = (r_state == S_EXEC);
    assign any_hit = |hit;
    assign full    = (r_count == CW'(ENTRIES));
    assign len_ok  = len_valid(r_len);

    always_comb begin
        cmd.key      = r_key;
        cmd.len      = r_len;
        cmd.data     = r_data;
        cmd.set_en   = exec && (r_action == ACT_SET) && len_ok;
        cmd.append   = !any_hit && !full;
        cmd.clear_en = exec && (r_action == ACT_CLEAR);
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic   hit_prev;
        t_entry next_ent;
        if (i == 0) begin : g_first
            assign hit_prev = 1'b0;
        end else begin : g_rest
            assign hit_prev = chain[i-1];
        end
        if (i < ENTRIES - 1) begin : g_mid
            assign next_ent = ent[i+1];
        end else begin : g_last
            assign next_ent = ent[i];
        end
        kot_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_valid     (CW'(i) < r_count),
            .i_is_tail   (CW'(i) == r_count),
            .i_hit_prev  (hit_prev),
            .i_next      (next_ent),
            .o_entry     (ent[i]),
            .o_hit       (hit[i]),
            .o_hit_chain (chain[i])
        );
    end

    // result and count for the execute cycle
    always_comb begin
        n_flen  = '0;
        n_fdata = '0;
        n_ok    = 1'b0;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit[i]) begin
                n_flen  = n_flen | ent[i].len;
                n_fdata = n_fdata | ent[i].data;
            end
        end
        case (r_action)
            ACT_FIND: begin
                n_ok = any_hit;
            end
            ACT_SET: begin
                n_ok = len_ok && (any_hit || !full);
                if (len_ok && !any_hit && !full) begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_CLEAR: begin
                n_ok = any_hit;
                if (any_hit) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (r_action != ACT_FIND || !any_hit) begin
            n_flen  = '0;
            n_fdata = '0;
        end
    end

    assign count_x = XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state  <= S_EXEC;
                        r_action <= i_action;
                        r_key    <= i_reg_addr;
                        r_len    <= i_payload_len;
                        r_data   <= i_payload & byte_mask(i_payload_len);
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_count     <= n_count;
                    r_out_valid <= 1'b1;
                    r_ok        <= n_ok;
                    r_flen      <= n_flen;
                    r_fdata     <= n_fdata;
                    r_ecount    <= count_x[COUNT_OUT_W-1:0];
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = exec;
    assign o_valid       = r_out_valid;
    assign o_ok          = r_ok;
    assign o_found_len   = r_flen;
    assign o_found_data  = r_fdata;
    assign o_entry_count = r_ecount;

`ifndef SYNTH
    // keys stay unique, so at most one valid cell can match
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |-> $onehot0(hit))
        else $error("more than one cell matched the key");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count above table size");

    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without an execute cycle");

    a_find_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_len != '0) |-> (o_ok && o_found_len <= LEN_W'(MAX_BYTES)))
        else $error("bad length on a find result");
`endif

endmodule

@@ rtl/kot_cell.sv @@
// one table slot: key compare, in-place write, append and shift-down from neighbor
module kot_cell (
    input  logic           i_clk,
    input  kot_pkg::t_cmd   i_cmd,
    input  logic           i_valid,
    input  logic           i_is_tail,
    input  logic           i_hit_prev,
    input  kot_pkg::t_entry i_next,
    output kot_pkg::t_entry o_entry,
    output logic           o_hit,
    output logic           o_hit_chain
);
    import kot_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry     = r_entry;
    assign o_hit       = i_valid && (r_entry.key == i_cmd.key);
    // set once the matching slot is at or below this one
    assign o_hit_chain = i_hit_prev || o_hit;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.set_en && (o_hit || (i_cmd.append && i_is_tail))) begin
            n_entry.key  = i_cmd.key;
            n_entry.len  = i_cmd.len;
            n_entry.data = i_cmd.data;
        end else if (i_cmd.clear_en && o_hit_chain) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ dv/keyed_override_table_tb.sv @@
// self-checking testbench for the keyed override table: directed rows, then random beats
`timescale 1ns / 1ps

module keyed_override_table_tb;
    import kot_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_BEATS = 1100;
    localparam int QUIET_TAIL = 200;
    localparam int KEY_POOL = 24;
    localparam int CYCLE_LIMIT = 200000;
    // the one action code the package leaves unnamed
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef struct packed {
        logic                   ok;
        logic [LEN_W-1:0]       flen;
        logic [DATA_W-1:0]      fdata;
        logic [COUNT_OUT_W-1:0] cnt;
    } t_outcome;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] pay;
        logic [LEN_W-1:0]  plen;
        logic [7:0]        reps;
        logic              typed;
        t_outcome          want;
    } t_vector;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [ACT_W-1:0]       i_action;
    logic [KEY_W-1:0]       i_reg_addr;
    logic [DATA_W-1:0]      i_payload;
    logic [LEN_W-1:0]       i_payload_len;
    logic                   o_valid;
    logic                   o_ok;
    logic [LEN_W-1:0]       o_found_len;
    logic [DATA_W-1:0]      o_found_data;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    // shadow copy of the table
    logic [KEY_W-1:0]  shadow_key [TABLE_DEPTH];
    logic [LEN_W-1:0]  shadow_len [TABLE_DEPTH];
    logic [DATA_W-1:0] shadow_data [TABLE_DEPTH];
    int                shadow_count;

    t_outcome pending_results[$];
    t_vector  directed_rows[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    int fail_count;
    int cycle_count;
    bit idle_on;

    keyed_override_table #(
        .ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_reg_addr(i_reg_addr),
        .i_payload(i_payload),
        .i_payload_len(i_payload_len),
        .o_valid(o_valid),
        .o_ok(o_ok),
        .o_found_len(o_found_len),
        .o_found_data(o_found_data),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] kept_bytes(input logic [LEN_W-1:0] len);
        if (len >= LEN_W'(MAX_BYTES)) return ALL_ONES;
        return (64'h1 << (8 * len)) - 64'h1;
    endfunction

    // apply one beat to the shadow table and return the result it should give
    function automatic t_outcome apply_table_op(input logic [ACT_W-1:0] act,
                                                input logic [KEY_W-1:0] key,
                                                input logic [DATA_W-1:0] pay,
                                                input logic [LEN_W-1:0] plen);
        t_outcome r;
        int hit;
        r = '0;
        hit = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_key[i] == key) hit = i;
        end
        case (act)
            ACT_FIND: begin
                if (hit < shadow_count) begin
                    r.ok = 1'b1;
                    r.flen = shadow_len[hit];
                    r.fdata = shadow_data[hit];
                end
            end
            ACT_SET: begin
                if (plen >= 1 && plen <= LEN_W'(MAX_BYTES)) begin
                    if (hit == shadow_count && shadow_count < TABLE_DEPTH) begin
                        shadow_count++;
                        r.ok = 1'b1;
                    end else if (hit < shadow_count) begin
                        r.ok = 1'b1;
                    end
                    if (r.ok) begin
                        shadow_key[hit] = key;
                        shadow_len[hit] = plen;
                        shadow_data[hit] = pay & kept_bytes(plen);
                    end
                end
            end
            ACT_CLEAR: begin
                if (hit < shadow_count) begin
                    for (int k = hit; k + 1 < shadow_count; k++) begin
                        shadow_key[k] = shadow_key[k + 1];
                        shadow_len[k] = shadow_len[k + 1];
                        shadow_data[k] = shadow_data[k + 1];
                    end
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.cnt = COUNT_OUT_W'(shadow_count);
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (fail_count < 40)
            $display("mismatch on %s: got %h, want %h (cycle %0d)", field, got, want,
                     cycle_count);
        fail_count++;
    endtask

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] pay, input logic [LEN_W-1:0] plen,
                           input int reps, input bit typed, input logic ok,
                           input logic [LEN_W-1:0] flen, input logic [DATA_W-1:0] fdata,
                           input int cnt);
        t_vector v;
        v.act = act;
        v.key = key;
        v.pay = pay;
        v.plen = plen;
        v.reps = 8'(reps);
        v.typed = typed;
        v.want.ok = ok;
        v.want.flen = flen;
        v.want.fdata = fdata;
        v.want.cnt = COUNT_OUT_W'(cnt);
        directed_rows.push_back(v);
    endtask

    // present one beat, hold it until accepted, then log what it should give
    task automatic issue_beat(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] pay, input logic [LEN_W-1:0] plen,
                              input bit typed, input t_outcome want);
        t_outcome predicted;
        start <= 1'b1;
        i_action <= act;
        i_reg_addr <= key;
        i_payload <= pay;
        i_payload_len <= plen;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = apply_table_op(act, key, pay, plen);
        pending_results.push_back(typed ? want : predicted);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected beat", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) flag_mismatch("ok", DATA_W'(o_ok), DATA_W'(want.ok));
                if (o_found_len !== want.flen)
                    flag_mismatch("found_len", DATA_W'(o_found_len), DATA_W'(want.flen));
                if (o_found_data !== want.fdata)
                    flag_mismatch("found_data", o_found_data, want.fdata);
                if (o_entry_count !== want.cnt)
                    flag_mismatch("entry_count", DATA_W'(o_entry_count), DATA_W'(want.cnt));
            end
        end
    end

    initial begin
        t_vector v;
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] plen;
        logic [DATA_W-1:0] pay;
        bit filling;
        int roll;

        fail_count = 0;
        cycle_count = 0;
        shadow_count = 0;
        idle_on = 1'b0;
        filling = 1'b1;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_action <= ACT_FIND;
        i_reg_addr <= '0;
        i_payload <= '0;
        i_payload_len <= '0;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);

        // empty table, bad lengths, unused code
        add_row(ACT_FIND, 8'h00, '0, 4'd1, 1, 1, 0, 0, '0, 0);
        add_row(ACT_CLEAR, 8'h00, '0, 4'd1, 1, 1, 0, 0, '0, 0);
        add_row(ACT_SET, 8'h10, ALL_ONES, 4'd0, 1, 1, 0, 0, '0, 0);
        add_row(ACT_SET, 8'h10, ALL_ONES, 4'd9, 1, 1, 0, 0, '0, 0);
        add_row(ACT_SET, 8'h10, ALL_ONES, 4'd15, 1, 1, 0, 0, '0, 0);
        add_row(ACT_NONE, 8'h10, ALL_ONES, 4'd8, 1, 1, 0, 0, '0, 0);
        // extreme keys and lengths
        add_row(ACT_SET, 8'h00, ALL_ONES, 4'd8, 1, 1, 1, 0, '0, 1);
        add_row(ACT_FIND, 8'h00, '0, 4'd0, 1, 1, 1, 4'd8, ALL_ONES, 1);
        add_row(ACT_SET, 8'hff, ALL_ONES, 4'd1, 1, 1, 1, 0, '0, 2);
        add_row(ACT_FIND, 8'hff, '0, 4'd0, 1, 1, 1, 4'd1, 64'hff, 2);
        // update in place with a shorter length
        add_row(ACT_SET, 8'h00, 64'h0123_4567_89ab_cdef, 4'd3, 1, 0, 0, 0, '0, 0);
        add_row(ACT_FIND, 8'h00, '0, 4'd0, 1, 0, 0, 0, '0, 0);
        // fill up, then a new key on a full table
        add_row(ACT_SET, 8'h20, 64'h5a5a_c3c3_0f0f_9696, 4'd8, 14, 0, 0, 0, '0, 0);
        add_row(ACT_SET, 8'h80, ALL_ONES, 4'd4, 1, 1, 0, 0, '0, 16);
        add_row(ACT_SET, 8'hff, 64'hfedc_ba98_7654_3210, 4'd8, 1, 0, 0, 0, '0, 0);
        // clear the first entry so everything shifts
        add_row(ACT_CLEAR, 8'h00, '0, 4'd0, 1, 0, 0, 0, '0, 0);
        add_row(ACT_FIND, 8'hff, '0, 4'd0, 1, 0, 0, 0, '0, 0);
        add_row(ACT_FIND, 8'h00, '0, 4'd0, 1, 1, 0, 0, '0, 15);
        add_row(ACT_CLEAR, 8'h2d, '0, 4'd0, 1, 0, 0, 0, '0, 0);
        add_row(ACT_FIND, 8'h2d, '0, 4'd0, 1, 1, 0, 0, '0, 14);
        add_row(ACT_SET, 8'h7f, '0, 4'd8, 1, 0, 0, 0, '0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            v = directed_rows[n];
            for (int r = 0; r < v.reps; r++)
                issue_beat(v.act, v.key + KEY_W'(r), v.pay + DATA_W'(r), v.plen, v.typed, v.want);
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (n >= RANDOM_BEATS - QUIET_TAIL) idle_on = 1'b0;
            // swing the table between nearly empty (one entry or none) and full
            if (shadow_count == TABLE_DEPTH) filling = 1'b0;
            else if (shadow_count <= 1) filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3) act = ACT_NONE;
            else if (roll < 28) act = ACT_FIND;
            else if (roll < (filling ? 75 : 50)) act = ACT_SET;
            else act = ACT_CLEAR;
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(0, 255))
                                              : key_pool[$urandom_range(0, KEY_POOL - 1)];
            if ($urandom_range(0, 9) == 0)
                plen = $urandom_range(0, 1) ? 4'd0 : LEN_W'($urandom_range(9, 15));
            else
                plen = LEN_W'($urandom_range(1, 8));
            case ($urandom_range(0, 15))
                0: pay = ALL_ONES;
                1: pay = '0;
                default: pay = {$urandom, $urandom};
            endcase
            issue_beat(act, key, pay, plen, 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
